>>> design/cfr_pkg.sv
`timescale 1ns / 1ps

package cfr_pkg;

  // Sizes of the fixed-width fields.
  localparam int BYTE_W       = 8;
  localparam int KIND_W       = 2;
  localparam int POS_W        = 5;
  localparam int LEN_REG_W    = 6;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;

  // Lengths are compared at this width (covers a buffer of up to 127 bytes).
  localparam int LEN_CMP_W    = 7;

  // Buffer depth default and the cap on results per frame.
  localparam int DEFAULT_PAYLOAD_DEPTH = 32;
  localparam int MAX_EMIT              = 32;

  typedef logic [KIND_W-1:0]      kind_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Frame kinds as they appear on the result channel.
  localparam kind_t KIND_PULSE    = 2'd0;
  localparam kind_t KIND_DISTANCE = 2'd1;
  localparam kind_t KIND_ZERO     = 2'd2;

  // Configuration register indexes.
  localparam cfg_index_t REG_START_MARKER   = 3'd0;
  localparam cfg_index_t REG_PULSE_ID       = 3'd1;
  localparam cfg_index_t REG_DISTANCE_ID    = 3'd2;
  localparam cfg_index_t REG_ZERO_ID        = 3'd3;
  localparam cfg_index_t REG_PULSE_LENGTH   = 3'd4;
  localparam cfg_index_t REG_DISTANCE_LENGTH = 3'd5;
  localparam cfg_index_t REG_ZERO_LENGTH    = 3'd6;

endpackage

>>> design/cfr_ram.sv
`timescale 1ns / 1ps

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/command_frame_receiver.sv
`timescale 1ns / 1ps
// The input takes one byte per cycle while parsing, as long as no drain is in
// progress. After an accepted pulse or millimetre frame the input stalls while
// each emitted byte is read from the payload RAM and then loaded into the output
// register; after a zero frame it stalls while the marker beat is loaded, and
// longer while the output is stalled. The first result of an accepted frame
// follows its checksum beat through the drain states into the output register.
// Reset clears the parser, drain sequencer and output valid and loads the
// configuration registers with their defaults; the payload RAM is not cleared.
module command_frame_receiver #(
  parameter int PAYLOAD_DEPTH = cfr_pkg::DEFAULT_PAYLOAD_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cfr_pkg::BYTE_W-1:0]   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cfr_pkg::KIND_W-1:0]   frame_kind,
  output logic [cfr_pkg::BYTE_W-1:0]   payload_byte,
  output logic [cfr_pkg::POS_W-1:0]    byte_position,
  output logic                         last_of_frame,
  input  logic                         cfg_write,
  input  logic [cfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import cfr_pkg::*;

  localparam int LW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_CMD     = 5'b00010,
    PH_LEN     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    DR_IDLE = 4'b0001,
    DR_READ = 4'b0010,
    DR_WAIT = 4'b0100,
    DR_ZERO = 4'b1000
  } drain_t;

  // Configuration registers.
  logic [BYTE_W-1:0]    start_marker;
  logic [BYTE_W-1:0]    pulse_command_id;
  logic [BYTE_W-1:0]    distance_command_id;
  logic [BYTE_W-1:0]    zero_command_id;
  logic [LEN_REG_W-1:0] pulse_payload_length;
  logic [LEN_REG_W-1:0] distance_payload_length;
  logic [LEN_REG_W-1:0] zero_payload_length;

  // Parser state.
  phase_t            phase;
  logic [BYTE_W-1:0] command_id;
  logic [LW-1:0]     frame_length;
  logic [LW-1:0]     byte_count;
  logic [BYTE_W-1:0] running_xor;

  // Drain sequencer state.
  drain_t        drain;
  kind_t         emit_kind;
  logic [LW-1:0] emit_count;
  logic [LW-1:0] rd_idx;

  logic              in_beat;
  logic              out_beat;
  logic              slot_free;
  logic              ram_we;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic [LW-1:0]     byte_count_next;
  logic [LW-1:0]     rd_idx_next;
  logic              len_ok;
  logic              match_pulse;
  logic              match_distance;
  logic              match_zero;
  logic              sum_ok;
  logic [LEN_CMP_W-1:0] len_ext;
  logic [LW-1:0]     capped_count;

  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (drain != DR_IDLE);

  assign byte_count_next = byte_count + 1'b1;
  assign rd_idx_next     = rd_idx + 1'b1;
  assign len_ok = (rx_byte != '0) && (rx_byte <= BYTE_W'(PAYLOAD_DEPTH));

  // Frame classification at the checksum beat; pulse has priority, then millimetre.
  assign len_ext        = LEN_CMP_W'(frame_length);
  assign sum_ok         = (rx_byte == running_xor);
  assign match_pulse    = (command_id == pulse_command_id)
                          && (len_ext == LEN_CMP_W'(pulse_payload_length));
  assign match_distance = (command_id == distance_command_id)
                          && (len_ext == LEN_CMP_W'(distance_payload_length));
  assign match_zero     = (command_id == zero_command_id)
                          && (len_ext == LEN_CMP_W'(zero_payload_length));
  assign capped_count   = (len_ext > LEN_CMP_W'(MAX_EMIT)) ? LW'(MAX_EMIT) : frame_length;

  assign ram_we = in_beat && (phase == PH_PAYLOAD);
  assign ram_re = (drain == DR_READ) && slot_free;

  cfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (rx_byte),
    .re    (ram_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker            <= 8'd170;
      pulse_command_id        <= 8'd1;
      distance_command_id     <= 8'd2;
      zero_command_id         <= 8'd3;
      pulse_payload_length    <= 6'd4;
      distance_payload_length <= 6'd4;
      zero_payload_length     <= 6'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_MARKER:    start_marker            <= cfg_data;
        REG_PULSE_ID:        pulse_command_id        <= cfg_data;
        REG_DISTANCE_ID:     distance_command_id     <= cfg_data;
        REG_ZERO_ID:         zero_command_id         <= cfg_data;
        REG_PULSE_LENGTH:    pulse_payload_length    <= cfg_data[LEN_REG_W-1:0];
        REG_DISTANCE_LENGTH: distance_payload_length <= cfg_data[LEN_REG_W-1:0];
        REG_ZERO_LENGTH:     zero_payload_length     <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte parser. Payload bytes go to the RAM, the checksum is kept as a running XOR.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      command_id   <= '0;
      frame_length <= '0;
      byte_count   <= '0;
      running_xor  <= '0;
    end else if (in_beat) begin
      case (phase)
        PH_START: begin
          if (rx_byte == start_marker) begin
            phase <= PH_CMD;
          end
        end
        PH_CMD: begin
          command_id <= rx_byte;
          phase      <= PH_LEN;
        end
        PH_LEN: begin
          byte_count   <= '0;
          running_xor  <= '0;
          frame_length <= LW'(rx_byte);
          phase        <= len_ok ? PH_PAYLOAD : PH_START;
        end
        PH_PAYLOAD: begin
          running_xor <= running_xor ^ rx_byte;
          byte_count  <= byte_count_next;
          if (byte_count_next >= frame_length) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase <= PH_START;
        end
        default: begin
          phase <= PH_START;
        end
      endcase
    end
  end

  // Drain sequencer: reads the stored payload a byte at a time, or emits a zero marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      drain <= DR_IDLE;
    end else begin
      case (drain)
        DR_IDLE: begin
          if (in_beat && (phase == PH_CHECK) && sum_ok) begin
            if (match_pulse || match_distance) begin
              drain <= DR_READ;
            end else if (match_zero) begin
              drain <= DR_ZERO;
            end
          end
        end
        DR_READ: begin
          if (slot_free) begin
            drain <= DR_WAIT;
          end
        end
        DR_WAIT: begin
          drain <= (rd_idx_next == emit_count) ? DR_IDLE : DR_READ;
        end
        DR_ZERO: begin
          if (slot_free) begin
            drain <= DR_IDLE;
          end
        end
        default: begin
          drain <= DR_IDLE;
        end
      endcase
    end
  end

  // Frame descriptor and read index for the drain.
  always_ff @(posedge clk) begin
    if ((drain == DR_IDLE) && in_beat && (phase == PH_CHECK)) begin
      emit_kind  <= match_pulse ? KIND_PULSE : KIND_DISTANCE;
      emit_count <= capped_count;
      rd_idx     <= '0;
    end else if (drain == DR_WAIT) begin
      rd_idx <= rd_idx_next;
    end
  end

  // Output register; a result loads only when the slot is free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((drain == DR_WAIT) || ((drain == DR_ZERO) && slot_free)) begin
      out_valid <= 1'b1;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain == DR_WAIT) begin
      frame_kind    <= emit_kind;
      payload_byte  <= ram_rdata;
      byte_position <= POS_W'(rd_idx);
      last_of_frame <= (rd_idx_next == emit_count);
    end else if ((drain == DR_ZERO) && slot_free) begin
      frame_kind    <= KIND_ZERO;
      payload_byte  <= '0;
      byte_position <= '0;
      last_of_frame <= 1'b1;
    end
  end

endmodule

>>> design/cfr_checker.sv
`timescale 1ns / 1ps

module cfr_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [cfr_pkg::KIND_W-1:0]   frame_kind,
  input  logic [cfr_pkg::BYTE_W-1:0]   payload_byte,
  input  logic [cfr_pkg::POS_W-1:0]    byte_position,
  input  logic                         last_of_frame
);

  import cfr_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_kind) && $stable(payload_byte)
      && $stable(byte_position) && $stable(last_of_frame))
    else $error("result beat changed while stalled");

  // A zero frame gives one marker beat with no payload.
  a_zero_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == KIND_ZERO) |->
      (payload_byte == '0) && (byte_position == '0) && last_of_frame)
    else $error("zero frame beat malformed");

  // While a payload burst is still being drained, no new byte is taken.
  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_frame |=> in_stall)
    else $error("input accepted in the middle of a payload burst");

  // After a non-final burst beat, the next beat follows its RAM read, one position on.
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_frame |=> ##1 out_valid
      && (byte_position == $past(byte_position, 2) + 1'b1))
    else $error("byte position did not advance within a burst");

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);

>>> tb/command_frame_receiver_tb.sv
`timescale 1ns / 1ps

module command_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int BODY_MAX      = DEFAULT_PAYLOAD_DEPTH;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 30;
  localparam cfg_index_t REG_UNUSED = 3'd7;

  typedef enum logic [2:0] {
    HUNT, WANT_ID, WANT_LENGTH, WANT_BODY, WANT_CHECKSUM
  } parse_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      rx_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [KIND_W-1:0]      frame_kind;
  logic [BYTE_W-1:0]      payload_byte;
  logic [POS_W-1:0]       byte_position;
  logic                   last_of_frame;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  command_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_kind   (frame_kind),
    .payload_byte (payload_byte),
    .byte_position(byte_position),
    .last_of_frame(last_of_frame),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Mirror of the configuration registers, starting from their reset values.
  logic [7:0] marker_reg      = 8'd170;
  logic [7:0] pulse_id_reg    = 8'd1;
  logic [7:0] distance_id_reg = 8'd2;
  logic [7:0] zero_id_reg     = 8'd3;
  logic [5:0] pulse_len_reg    = 6'd4;
  logic [5:0] distance_len_reg = 6'd4;
  logic [5:0] zero_len_reg     = 6'd1;

  // Mirror of the frame parser.
  parse_state_t parse_state = HUNT;
  logic [7:0]   frame_id    = '0;
  logic [5:0]   frame_len   = '0;
  logic [5:0]   body_count  = '0;
  logic [7:0]   body_xor    = '0;
  logic [7:0]   body_store [BODY_MAX];

  frame_result_t pending_results [$];
  int            fail_count   = 0;
  int            frame_beats  = 0;
  bit            sender_gaps_on = 1'b1;

  // Receiver stall bookkeeping.
  int hold_request = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  int calm_left    = 0;
  int idle_cycles  = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advance the parser mirror by one accepted byte and queue any frame results.
  task automatic track_rx_byte(input logic [7:0] b);
    kind_t         kind;
    logic          hit;
    int            count;
    frame_result_t r;
    case (parse_state)
      HUNT: begin
        if (b == marker_reg) parse_state = WANT_ID;
      end
      WANT_ID: begin
        frame_id    = b;
        parse_state = WANT_LENGTH;
      end
      WANT_LENGTH: begin
        body_count = '0;
        body_xor   = '0;
        frame_len  = b[5:0];
        if (b != 8'd0 && b <= BODY_MAX) parse_state = WANT_BODY;
        else parse_state = HUNT;
      end
      WANT_BODY: begin
        body_store[body_count] = b;
        body_xor   = body_xor ^ b;
        body_count = body_count + 6'd1;
        if (body_count >= frame_len) parse_state = WANT_CHECKSUM;
      end
      WANT_CHECKSUM: begin
        hit  = 1'b1;
        kind = KIND_PULSE;
        if (b != body_xor) hit = 1'b0;
        else if (frame_id == pulse_id_reg && frame_len == pulse_len_reg) kind = KIND_PULSE;
        else if (frame_id == distance_id_reg && frame_len == distance_len_reg)
          kind = KIND_DISTANCE;
        else if (frame_id == zero_id_reg && frame_len == zero_len_reg) kind = KIND_ZERO;
        else hit = 1'b0;
        if (hit && kind == KIND_ZERO) begin
          r.kind = KIND_ZERO;
          r.data = '0;
          r.pos  = '0;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else if (hit) begin
          // Payload frames replay the stored bytes, capped at the emit limit.
          count = (frame_len > MAX_EMIT) ? MAX_EMIT : int'(frame_len);
          for (int i = 0; i < count; i++) begin
            r.kind = kind;
            r.data = body_store[i];
            r.pos  = POS_W'(i);
            r.last = (i == count - 1);
            pending_results.push_back(r);
          end
        end
        parse_state = HUNT;
      end
      default: parse_state = HUNT;
    endcase
  endtask

  function automatic int next_gap();
    int r;
    if (!sender_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one byte, hold it until the beat is taken, then maybe idle a while.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_rx_byte(b);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_START_MARKER:    marker_reg       = data;
      REG_PULSE_ID:        pulse_id_reg     = data;
      REG_DISTANCE_ID:     distance_id_reg  = data;
      REG_ZERO_ID:         zero_id_reg      = data;
      REG_PULSE_LENGTH:    pulse_len_reg    = data[5:0];
      REG_DISTANCE_LENGTH: distance_len_reg = data[5:0];
      REG_ZERO_LENGTH:     zero_len_reg     = data[5:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    cfg_data  <= 8'($urandom);
    @(posedge clk);
  endtask

  // Close any open frame without producing results, then wait for the
  // output to drain so that registers can be rewritten safely.
  task automatic drain_and_settle();
    while (parse_state != HUNT) begin
      if (parse_state == WANT_CHECKSUM) send_byte(~body_xor);
      else send_byte(8'h00);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic fill_random(output logic [7:0] body [BODY_MAX]);
    int pick;
    for (int i = 0; i < BODY_MAX; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) body[i] = 8'h00;
      else if (pick == 1) body[i] = 8'hFF;
      else body[i] = 8'($urandom);
    end
  endtask

  // Send marker, id, length, payload and checksum. A length outside the
  // buffer ends the frame right after the length byte.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len_byte,
                            input logic [7:0] body [BODY_MAX], input bit corrupt);
    int         n;
    logic [7:0] checksum;
    n        = (len_byte != 8'd0 && len_byte <= BODY_MAX) ? int'(len_byte) : 0;
    checksum = '0;
    send_byte(marker_reg);
    send_byte(id);
    send_byte(len_byte);
    for (int i = 0; i < n; i++) begin
      send_byte(body[i]);
      checksum = checksum ^ body[i];
    end
    if (n > 0) send_byte(corrupt ? checksum ^ 8'($urandom_range(1, 255)) : checksum);
    frame_beats += (n > 0) ? n + 4 : 3;
  endtask

  task automatic test_reset_values();
    logic [7:0] body [BODY_MAX];
    fill_random(body);
    body[0] = 8'h00;
    body[1] = 8'hFF;
    body[2] = 8'h5A;
    body[3] = 8'hA5;
    send_frame(8'd1, 8'd4, body, 1'b0);
    fill_random(body);
    send_frame(8'd2, 8'd4, body, 1'b0);
    body[0] = 8'hFF;
    send_frame(8'd3, 8'd1, body, 1'b0);
    drain_and_settle();
  endtask

  // Bad lengths, checksums, unknown kinds drop silently; then one good frame.
  task automatic test_rejected_frames();
    logic [7:0] body [BODY_MAX];
    fill_random(body);
    send_frame(8'd1, 8'd0, body, 1'b0);
    send_frame(8'd1, 8'd33, body, 1'b0);
    send_frame(8'd1, 8'hFF, body, 1'b0);
    send_frame(8'd1, 8'd4, body, 1'b1);
    send_frame(8'h77, 8'd4, body, 1'b0);
    send_frame(8'd1, 8'd5, body, 1'b0);
    send_frame(8'd3, 8'd1, body, 1'b1);
    send_frame(8'd2, 8'd4, body, 1'b0);
    drain_and_settle();
  endtask

  // With overlapping kinds, pulse beats millimetre and millimetre beats zero.
  task automatic test_kind_priority();
    logic [7:0] body [BODY_MAX];
    fill_random(body);
    write_reg(REG_PULSE_ID, 8'h5C);
    write_reg(REG_DISTANCE_ID, 8'h5C);
    write_reg(REG_ZERO_ID, 8'h5C);
    write_reg(REG_PULSE_LENGTH, 8'd2);
    write_reg(REG_DISTANCE_LENGTH, 8'd2);
    write_reg(REG_ZERO_LENGTH, 8'd2);
    send_frame(8'h5C, 8'd2, body, 1'b0);
    drain_and_settle();
    write_reg(REG_PULSE_LENGTH, 8'd3);
    send_frame(8'h5C, 8'd2, body, 1'b0);
    drain_and_settle();
    write_reg(REG_DISTANCE_LENGTH, 8'd3);
    send_frame(8'h5C, 8'd2, body, 1'b0);
    send_frame(8'h5C, 8'd3, body, 1'b0);
    drain_and_settle();
  endtask

  // Register extremes; upper data bits of length registers are dropped and
  // the unused index has no effect.
  task automatic test_register_extremes();
    logic [7:0] body [BODY_MAX];
    fill_random(body);
    write_reg(REG_START_MARKER, 8'h00);
    write_reg(REG_PULSE_ID, 8'h00);
    write_reg(REG_DISTANCE_ID, 8'hFF);
    write_reg(REG_ZERO_ID, 8'h80);
    write_reg(REG_PULSE_LENGTH, 8'hE0);
    write_reg(REG_DISTANCE_LENGTH, 8'hC1);
    write_reg(REG_ZERO_LENGTH, 8'h3F);
    write_reg(REG_UNUSED, 8'hFF);
    send_frame(8'h00, 8'd32, body, 1'b0);
    send_frame(8'hFF, 8'd1, body, 1'b0);
    send_frame(8'h80, 8'd1, body, 1'b0);
    send_frame(8'h80, 8'd63, body, 1'b0);
    drain_and_settle();
    write_reg(REG_START_MARKER, 8'hFF);
    write_reg(REG_ZERO_LENGTH, 8'h1F);
    fill_random(body);
    send_frame(8'h80, 8'd31, body, 1'b0);
    send_frame(8'h00, 8'd32, body, 1'b0);
    drain_and_settle();
  endtask

  // The receiver holds off for a long stretch while full-size frames keep
  // coming, so the block backs up and stalls its input.
  task automatic test_output_hold_off();
    logic [7:0] body [BODY_MAX];
    write_reg(REG_START_MARKER, 8'hAA);
    write_reg(REG_PULSE_ID, 8'h01);
    write_reg(REG_PULSE_LENGTH, 8'd32);
    sender_gaps_on = 1'b0;
    hold_request <= hold_request + 1;
    repeat (4) begin
      fill_random(body);
      send_frame(8'h01, 8'd32, body, 1'b0);
    end
    sender_gaps_on = 1'b1;
    drain_and_settle();
  endtask

  function automatic logic [5:0] random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 6'($urandom_range(1, 6));
    if (r < 85) return 6'd32;
    if (r < 95) return 6'($urandom_range(7, 31));
    return 6'($urandom_range(0, 63));
  endfunction

  // Ids often share one value so that kinds overlap.
  task automatic randomize_registers();
    logic [7:0] shared_id;
    shared_id = 8'($urandom);
    write_reg(REG_START_MARKER, 8'($urandom));
    write_reg(REG_PULSE_ID, ($urandom_range(0, 9) < 4) ? shared_id : 8'($urandom));
    write_reg(REG_DISTANCE_ID, ($urandom_range(0, 9) < 4) ? shared_id : 8'($urandom));
    write_reg(REG_ZERO_ID, ($urandom_range(0, 9) < 4) ? shared_id : 8'($urandom));
    write_reg(REG_PULSE_LENGTH, {2'($urandom), random_length()});
    write_reg(REG_DISTANCE_LENGTH, {2'($urandom), random_length()});
    write_reg(REG_ZERO_LENGTH, {2'($urandom), random_length()});
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, 8'($urandom));
  endtask

  // Mostly well-formed frames of configured kinds, some random frames and
  // some stray bytes.
  task automatic send_random_frame();
    int         pick;
    logic [7:0] body [BODY_MAX];
    logic [7:0] id;
    logic [7:0] len_byte;
    fill_random(body);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 2))
        0: begin
          id       = pulse_id_reg;
          len_byte = {2'b00, pulse_len_reg};
        end
        1: begin
          id       = distance_id_reg;
          len_byte = {2'b00, distance_len_reg};
        end
        default: begin
          id       = zero_id_reg;
          len_byte = {2'b00, zero_len_reg};
        end
      endcase
      if (len_byte == 8'd0 || len_byte > BODY_MAX) len_byte = 8'($urandom_range(1, 6));
      send_frame(id, len_byte, body, $urandom_range(0, 9) == 0);
    end else if (pick < 85) begin
      id       = 8'($urandom);
      len_byte = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
      send_frame(id, len_byte, body, bit'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int start_beats;
    for (int phase = 0; phase < 5; phase++) begin
      randomize_registers();
      // One phase runs back to back with no sender gaps.
      sender_gaps_on = (phase != 2);
      start_beats = frame_beats;
      while (frame_beats - start_beats < PHASE_BEATS) send_random_frame();
      sender_gaps_on = 1'b1;
      drain_and_settle();
    end
  endtask

  // Receiver stall pattern: short and long stalls, calm stretches, and the
  // long hold-off requested by the pressure test.
  always @(posedge clk) begin : drive_out_stall
    int  pick;
    logic stall_now;
    stall_now = 1'b0;
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_now = 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        calm_left = $urandom_range(30, 150);
      end else if (pick < 20) begin
        stall_now  = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (pick < 23) begin
        stall_now  = 1'b1;
        stall_left = $urandom_range(10, 60);
      end
    end
    out_stall <= stall_now;
  end

  // Compare every result beat with the oldest expected result.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: frame_kind %0d payload_byte %02h byte_position %0d last %0b",
               frame_kind, payload_byte, byte_position, last_of_frame);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (frame_kind !== want.kind) begin
          $error("frame_kind: expected %0d, got %0d", want.kind, frame_kind);
          fail_count++;
        end
        if (payload_byte !== want.data) begin
          $error("payload_byte: expected %02h, got %02h", want.data, payload_byte);
          fail_count++;
        end
        if (byte_position !== want.pos) begin
          $error("byte_position: expected %0d, got %0d", want.pos, byte_position);
          fail_count++;
        end
        if (last_of_frame !== want.last) begin
          $error("last_of_frame: expected %0b, got %0b", want.last, last_of_frame);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_rejected_frames();
    test_kind_priority();
    test_register_extremes();
    test_output_hold_off();
    test_random_traffic();
    drain_and_settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
